### design/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared widths, codes, command types and calendar helpers for the calendar
// date adder.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int YEAR_BITS   = 16;
  localparam int AMOUNT_BITS = 16;

  localparam int D_BITS   = AMOUNT_BITS + 1;
  localparam int DIV_BITS = (YEAR_BITS > D_BITS) ? YEAR_BITS : D_BITS;
  localparam int SUM_BITS = DIV_BITS + 1;
  localparam int CNT_BITS = 2;
  localparam int CMP_BITS = (D_BITS > 18) ? D_BITS : 18;
  localparam int REM_BITS = 9;

  localparam int RECIP_SHIFT = DIV_BITS + REM_BITS;
  localparam int RECIP_BITS  = RECIP_SHIFT - 3;
  localparam int PROD_BITS   = DIV_BITS + RECIP_BITS;

  localparam logic [YEAR_BITS-1:0] MAX_YEAR = '1;
  localparam longint unsigned MAX_YEAR_L = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [REM_BITS-1:0] MAX_MOD400 = REM_BITS'(MAX_YEAR_L % 64'd400);

  localparam int unsigned DAYS_400Y = 146097;
  localparam logic [REM_BITS-1:0] DIVISOR_YEAR  = 9'd400;
  localparam logic [REM_BITS-1:0] DIVISOR_MONTH = 9'd12;

  localparam logic [RECIP_BITS-1:0] RECIP_YEAR =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd399) / 64'd400);
  localparam logic [RECIP_BITS-1:0] RECIP_MONTH =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12);
  localparam logic [CNT_BITS-1:0] DIV_STEPS = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD       = 2'd0,
    OP_ADD_DAYS   = 2'd1,
    OP_ADD_MONTHS = 2'd2,
    OP_ADD_YEARS  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CAPTURE,
    DP_DIV_STEP,
    DP_LOAD_EVAL,
    DP_YR_FIN,
    DP_MON_EVAL,
    DP_MON_FIN,
    DP_CYC_STEP,
    DP_MON_STEP,
    DP_DAY_SET,
    DP_SAT,
    DP_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic div_done;
    logic cyc_more;
    logic cyc_ovf;
    logic mon_fit;
    logic mon_ovf;
    logic mon_y_ovf;
    logic out_free;
  } dp_status_t;

  function automatic logic is_leap(logic [REM_BITS-1:0] mod400);
    return (mod400[1:0] == 2'd0) && (mod400 != 9'd100) && (mod400 != 9'd200) &&
           (mod400 != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
    logic [4:0] len;
    case (month)
      4'd2: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### design/cda_ctrl.sv
// ----------------------------------------------------------------------------
// cda_ctrl
// Command sequencer: steps the datapath through load, add and result phases.
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  cda_pkg::dp_status_t status_i,
  output cda_pkg::dp_cmd_e    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_A,
    S_DIV_B,
    S_CYC,
    S_MON,
    S_RESP
  } state_e;

  state_e           state_q, state_d;
  cda_pkg::opcode_e op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = cda_pkg::DP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = cda_pkg::DP_CAPTURE;
          op_d  = cda_pkg::opcode_e'(opcode_i);
          if (cda_pkg::opcode_e'(opcode_i) == cda_pkg::OP_ADD_DAYS) begin
            state_d = S_CYC;
          end else begin
            state_d = S_DIV_A;
          end
        end
      end
      S_DIV_A: begin
        if (!status_i.div_done) begin
          cmd_o = cda_pkg::DP_DIV_STEP;
        end else begin
          state_d = S_RESP;
          case (op_q)
            cda_pkg::OP_LOAD:      cmd_o = cda_pkg::DP_LOAD_EVAL;
            cda_pkg::OP_ADD_YEARS: cmd_o = cda_pkg::DP_YR_FIN;
            cda_pkg::OP_ADD_MONTHS: begin
              cmd_o = cda_pkg::DP_MON_EVAL;
              if (!status_i.mon_y_ovf) begin
                state_d = S_DIV_B;
              end
            end
            default: cmd_o = cda_pkg::DP_IDLE;
          endcase
        end
      end
      S_DIV_B: begin
        if (!status_i.div_done) begin
          cmd_o = cda_pkg::DP_DIV_STEP;
        end else begin
          cmd_o   = cda_pkg::DP_MON_FIN;
          state_d = S_RESP;
        end
      end
      S_CYC: begin
        if (!status_i.cyc_more) begin
          state_d = S_MON;
        end else if (status_i.cyc_ovf) begin
          cmd_o   = cda_pkg::DP_SAT;
          state_d = S_RESP;
        end else begin
          cmd_o = cda_pkg::DP_CYC_STEP;
        end
      end
      S_MON: begin
        if (status_i.mon_fit) begin
          cmd_o   = cda_pkg::DP_DAY_SET;
          state_d = S_RESP;
        end else if (status_i.mon_ovf) begin
          cmd_o   = cda_pkg::DP_SAT;
          state_d = S_RESP;
        end else begin
          cmd_o = cda_pkg::DP_MON_STEP;
        end
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o   = cda_pkg::DP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= cda_pkg::OP_LOAD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

### design/cda_datapath.sv
// ----------------------------------------------------------------------------
// cda_datapath
// Date registers, year-mod-400 tracking, reciprocal constant divider, day walk
// and output register.
// ----------------------------------------------------------------------------
module cda_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cda_pkg::dp_cmd_e        cmd_i,
  output cda_pkg::dp_status_t     status_o,
  input  logic [1:0]              opcode_i,
  input  logic [15:0]             amount_i,
  input  logic [15:0]             load_year_i,
  input  logic [3:0]              load_month_i,
  input  logic [4:0]              load_day_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [15:0]             cur_year_o,
  output logic [3:0]              cur_month_o,
  output logic [4:0]              cur_day_o,
  output logic [1:0]              status_out_o
);

  localparam int YB  = cda_pkg::YEAR_BITS;
  localparam int AB  = cda_pkg::AMOUNT_BITS;
  localparam int DB  = cda_pkg::D_BITS;
  localparam int VB  = cda_pkg::DIV_BITS;
  localparam int SB  = cda_pkg::SUM_BITS;
  localparam int CB  = cda_pkg::CNT_BITS;
  localparam int MB  = cda_pkg::CMP_BITS;
  localparam int RB  = cda_pkg::REM_BITS;
  localparam int PB  = cda_pkg::PROD_BITS;
  localparam int RCB = cda_pkg::RECIP_BITS;

  logic [YB-1:0]     year_q, year_d;
  logic [RB-1:0]     mod_q, mod_d;
  logic [3:0]        month_q, month_d;
  logic [4:0]        day_q, day_d;
  logic [DB-1:0]     dacc_q, dacc_d;
  logic [AB-1:0]     amt_q, amt_d;
  logic [15:0]       ly_q, ly_d;
  logic [3:0]        lm_q, lm_d;
  logic [4:0]        ld_q, ld_d;
  cda_pkg::status_e  st_q, st_d;
  logic [VB-1:0]     divn_q, divn_d;
  logic [RB-1:0]     rem_q, rem_d;
  logic [RB-1:0]     divs_q, divs_d;
  logic [PB-1:0]     prod_q, prod_d;
  logic [CB-1:0]     cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       oyear_q, oyear_d;
  logic [3:0]        omonth_q, omonth_d;
  logic [4:0]        oday_q, oday_d;
  logic [1:0]        ost_q, ost_d;

  logic [AB-1:0]     amt_in;
  logic [SB-1:0]     sum_in;
  logic [SB-1:0]     sum_yr;
  logic [SB-1:0]     sum_mon;
  logic [YB:0]       year_p400;
  logic [4:0]        len_cur;
  logic [4:0]        len_rem;
  logic [4:0]        len_load;
  logic [RCB-1:0]    recip;
  logic [VB-1:0]     quo;
  logic [VB-1:0]     quo_mul;
  logic              ly_over;
  logic              load_ok;
  logic              sat;

  assign amt_in    = AB'(amount_i);
  assign sum_in    = SB'(year_q) + SB'(amt_in);
  assign sum_yr    = SB'(year_q) + SB'(amt_q);
  assign sum_mon   = SB'(year_q) + SB'(divn_q);
  assign year_p400 = (YB + 1)'(year_q) + (YB + 1)'(400);
  assign len_cur   = cda_pkg::month_len(month_q, cda_pkg::is_leap(mod_q));
  assign len_rem   = cda_pkg::month_len(month_q, cda_pkg::is_leap(rem_q));
  assign len_load  = cda_pkg::month_len(lm_q, cda_pkg::is_leap(rem_q));
  assign recip     = (divs_q == cda_pkg::DIVISOR_MONTH) ? cda_pkg::RECIP_MONTH :
                                                          cda_pkg::RECIP_YEAR;
  assign quo       = VB'(prod_q >> cda_pkg::RECIP_SHIFT);
  assign quo_mul   = quo * VB'(divs_q);
  assign ly_over   = (32'(ly_q) >> YB) != 32'd0;
  assign load_ok   = !ly_over && (lm_q >= 4'd1) && (lm_q <= 4'd12) && (ld_q != 5'd0) &&
                     (ld_q <= len_load);

  assign status_o.div_done  = (cnt_q == '0);
  assign status_o.cyc_more  = MB'(dacc_q) > MB'(cda_pkg::DAYS_400Y);
  assign status_o.cyc_ovf   = year_p400 > (YB + 1)'(cda_pkg::MAX_YEAR);
  assign status_o.mon_fit   = dacc_q <= DB'(len_cur);
  assign status_o.mon_ovf   = (month_q == 4'd12) && (year_q == cda_pkg::MAX_YEAR);
  assign status_o.mon_y_ovf = sum_mon > SB'(cda_pkg::MAX_YEAR);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    year_d      = year_q;
    mod_d       = mod_q;
    month_d     = month_q;
    day_d       = day_q;
    dacc_d      = dacc_q;
    amt_d       = amt_q;
    ly_d        = ly_q;
    lm_d        = lm_q;
    ld_d        = ld_q;
    st_d        = st_q;
    divn_d      = divn_q;
    rem_d       = rem_q;
    divs_d      = divs_q;
    prod_d      = prod_q;
    cnt_d       = cnt_q;
    oyear_d     = oyear_q;
    omonth_d    = omonth_q;
    oday_d      = oday_q;
    ost_d       = ost_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sat         = 1'b0;
    case (cmd_i)
      cda_pkg::DP_CAPTURE: begin
        amt_d  = amt_in;
        ly_d   = load_year_i;
        lm_d   = load_month_i;
        ld_d   = load_day_i;
        st_d   = cda_pkg::ST_OK;
        dacc_d = DB'(day_q) + DB'(amt_in);
        rem_d  = '0;
        cnt_d  = cda_pkg::DIV_STEPS;
        case (cda_pkg::opcode_e'(opcode_i))
          cda_pkg::OP_LOAD: begin
            divn_d = VB'(load_year_i);
            divs_d = cda_pkg::DIVISOR_YEAR;
          end
          cda_pkg::OP_ADD_MONTHS: begin
            divn_d = VB'(month_q) - VB'(1) + VB'(amt_in);
            divs_d = cda_pkg::DIVISOR_MONTH;
          end
          default: begin
            divn_d = VB'(sum_in);
            divs_d = cda_pkg::DIVISOR_YEAR;
          end
        endcase
      end
      cda_pkg::DP_DIV_STEP: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CB'(1);
          if (cnt_q == cda_pkg::DIV_STEPS) begin
            prod_d = PB'(divn_q) * PB'(recip);
          end else begin
            divn_d = quo;
            rem_d  = RB'(divn_q - quo_mul);
          end
        end
      end
      cda_pkg::DP_LOAD_EVAL: begin
        if (load_ok) begin
          year_d  = YB'(ly_q);
          mod_d   = rem_q;
          month_d = lm_q;
          day_d   = ld_q;
        end else begin
          st_d = cda_pkg::ST_INVALID;
        end
      end
      cda_pkg::DP_YR_FIN: begin
        if (sum_yr > SB'(cda_pkg::MAX_YEAR)) begin
          sat = 1'b1;
        end else begin
          year_d = YB'(sum_yr);
          mod_d  = rem_q;
          if ((month_q == 4'd2) && (day_q == 5'd29) && !cda_pkg::is_leap(rem_q)) begin
            month_d = 4'd3;
            day_d   = 5'd1;
          end
        end
      end
      cda_pkg::DP_MON_EVAL: begin
        if (status_o.mon_y_ovf) begin
          sat = 1'b1;
        end else begin
          year_d  = YB'(sum_mon);
          month_d = 4'(rem_q) + 4'd1;
          divn_d  = VB'(sum_mon);
          divs_d  = cda_pkg::DIVISOR_YEAR;
          rem_d   = '0;
          cnt_d   = cda_pkg::DIV_STEPS;
        end
      end
      cda_pkg::DP_MON_FIN: begin
        mod_d = rem_q;
        if (day_q > len_rem) begin
          day_d = len_rem;
        end
      end
      cda_pkg::DP_CYC_STEP: begin
        year_d = YB'(year_p400);
        dacc_d = dacc_q - DB'(cda_pkg::DAYS_400Y);
      end
      cda_pkg::DP_MON_STEP: begin
        dacc_d = dacc_q - DB'(len_cur);
        if (month_q == 4'd12) begin
          year_d  = year_q + YB'(1);
          mod_d   = (mod_q == 9'd399) ? '0 : mod_q + 9'd1;
          month_d = 4'd1;
        end else begin
          month_d = month_q + 4'd1;
        end
      end
      cda_pkg::DP_DAY_SET: day_d = 5'(dacc_q);
      cda_pkg::DP_SAT:     sat = 1'b1;
      cda_pkg::DP_EMIT: begin
        oyear_d     = 16'(year_q);
        omonth_d    = month_q;
        oday_d      = day_q;
        ost_d       = st_q;
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
    if (sat) begin
      year_d  = cda_pkg::MAX_YEAR;
      mod_d   = cda_pkg::MAX_MOD400;
      month_d = 4'd12;
      day_d   = 5'd31;
      st_d    = cda_pkg::ST_SATURATED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q      <= '0;
      mod_q       <= '0;
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      cnt_q       <= '0;
      st_q        <= cda_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      year_q      <= year_d;
      mod_q       <= mod_d;
      month_q     <= month_d;
      day_q       <= day_d;
      cnt_q       <= cnt_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dacc_q   <= dacc_d;
    amt_q    <= amt_d;
    ly_q     <= ly_d;
    lm_q     <= lm_d;
    ld_q     <= ld_d;
    divn_q   <= divn_d;
    rem_q    <= rem_d;
    divs_q   <= divs_d;
    prod_q   <= prod_d;
    oyear_q  <= oyear_d;
    omonth_q <= omonth_d;
    oday_q   <= oday_d;
    ost_q    <= ost_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cur_year_o   = oyear_q;
  assign cur_month_o  = omonth_q;
  assign cur_day_o    = oday_q;
  assign status_out_o = ost_q;

endmodule

### design/calendar_date_adder.sv
// ----------------------------------------------------------------------------
// calendar_date_adder
// Gregorian date register with load, add-days, add-months and add-years
// commands; one result word per command word.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries a command word: opcode,
// amount and the date fields used by a load. The block works on one word at
// a time; in_ready_o is high only while the sequencer is idle.
// Output channel (out_valid_o / out_ready_i) carries the date after the
// command and a status code (ok, invalid load refused, year saturated).
// Steps from the accepting edge to the edge that registers the result:
//   load, add years: reciprocal divide by 400 (multiply, then quotient and
//     remainder), then update
//   add months: divide by 12, update, divide by 400, clamp the day; when the
//     year overflows it saturates after the first divide
//   add days: one step per 400-year block, then one step per month walked
// The next word is taken only after the result is registered, once the
// sequencer is idle again. While the receiver stalls the result waits in the
// output register; one more word is taken, runs and holds its result until the
// output register frees, and no further word is taken meanwhile.
// Reset sets the date to January 1 of year 0 and empties the output register.
// ----------------------------------------------------------------------------
module calendar_date_adder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] amount_i,
  input  logic [15:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] cur_year_o,
  output logic [3:0]  cur_month_o,
  output logic [4:0]  cur_day_o,
  output logic [1:0]  status_o
);

  cda_pkg::dp_cmd_e    cmd;
  cda_pkg::dp_status_t dp_status;

  cda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  cda_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .opcode_i     (opcode_i),
    .amount_i     (amount_i),
    .load_year_i  (load_year_i),
    .load_month_i (load_month_i),
    .load_day_i   (load_day_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cur_year_o   (cur_year_o),
    .cur_month_o  (cur_month_o),
    .cur_day_o    (cur_day_o),
    .status_out_o (status_o)
  );

endmodule

### design/calendar_date_adder_chk.sv
// ----------------------------------------------------------------------------
// calendar_date_adder_chk
// Port-level checks for the calendar date adder, bound to the top level.
// ----------------------------------------------------------------------------
module calendar_date_adder_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] cur_year_o,
  input logic [3:0]  cur_month_o,
  input logic [4:0]  cur_day_o,
  input logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cur_year_o) &&
    $stable(cur_month_o) && $stable(cur_day_o) && $stable(status_o))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new command taken while one is in progress");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cur_month_o >= 4'd1) && (cur_month_o <= 4'd12) &&
    (cur_day_o != 5'd0) && (status_o <= cda_pkg::ST_SATURATED))
    else $error("result word out of range");

  a_saturated_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == cda_pkg::ST_SATURATED) |->
    (cur_month_o == 4'd12) && (cur_day_o == 5'd31))
    else $error("saturated result is not December 31");

endmodule

bind calendar_date_adder calendar_date_adder_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .cur_year_o  (cur_year_o),
  .cur_month_o (cur_month_o),
  .cur_day_o   (cur_day_o),
  .status_o    (status_o)
);

### sim/calendar_date_adder_tb.sv
// ----------------------------------------------------------------------------
// calendar_date_adder testbench
// Drives command words (load, add days, add months, add years) into the date
// adder with random idle gaps on both channels, predicts each result word
// with a behavioral date model, and compares every returned date and status.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 250;

  typedef struct {
    opcode_e     op;
    logic [15:0] amount;
    logic [15:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
  } cmd_t;

  typedef struct {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    status_e     status;
  } date_result_t;

  class date_scoreboard;
    localparam int unsigned TOP_YEAR = 2 ** YEAR_BITS - 1;
    int unsigned  yr;
    int unsigned  mo;
    int unsigned  dy;
    date_result_t expected_dates[$];
    int           errors;
    int           n_checked;
    int           n_refused;
    int           n_saturated;

    function new();
      yr = 0;
      mo = 1;
      dy = 1;
      errors = 0;
      n_checked = 0;
      n_refused = 0;
      n_saturated = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned days_in_month(int unsigned y, int unsigned m);
      if (m == 2) return leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function status_e clamp_to_max();
      yr = TOP_YEAR;
      mo = 12;
      dy = 31;
      return ST_SATURATED;
    endfunction

    function status_e roll_days(int unsigned n);
      int unsigned d;
      d = dy + n;
      while (d > DAYS_400Y) begin
        if (yr + 400 > TOP_YEAR) return clamp_to_max();
        yr += 400;
        d -= DAYS_400Y;
      end
      while (d > days_in_month(yr, mo)) begin
        d -= days_in_month(yr, mo);
        mo++;
        if (mo > 12) begin
          if (yr >= TOP_YEAR) return clamp_to_max();
          yr++;
          mo = 1;
        end
      end
      dy = d;
      return ST_OK;
    endfunction

    function status_e roll_months(int unsigned n);
      int unsigned total;
      int unsigned y;
      int unsigned len;
      total = (mo - 1) + n;
      y = yr + total / 12;
      if (y > TOP_YEAR) return clamp_to_max();
      yr = y;
      mo = total % 12 + 1;
      len = days_in_month(yr, mo);
      if (dy > len) dy = len;
      return ST_OK;
    endfunction

    function status_e roll_years(int unsigned n);
      int unsigned y;
      y = yr + n;
      if (y > TOP_YEAR) return clamp_to_max();
      if (mo == 2 && dy == 29 && !leap_year(y)) begin
        mo = 3;
        dy = 1;
      end
      yr = y;
      return ST_OK;
    endfunction

    function date_result_t advance_date(cmd_t c);
      date_result_t r;
      status_e      st;
      st = ST_OK;
      case (c.op)
        OP_LOAD: begin
          if (c.load_year > TOP_YEAR || c.load_month < 1 || c.load_month > 12 ||
              c.load_day < 1 || c.load_day > days_in_month(c.load_year, c.load_month)) begin
            st = ST_INVALID;
          end else begin
            yr = c.load_year;
            mo = c.load_month;
            dy = c.load_day;
          end
        end
        OP_ADD_DAYS:   st = roll_days(c.amount);
        OP_ADD_MONTHS: st = roll_months(c.amount);
        default:       st = roll_years(c.amount);
      endcase
      r.year = yr[15:0];
      r.month = mo[3:0];
      r.day = dy[4:0];
      r.status = st;
      return r;
    endfunction

    function void note_command(cmd_t c);
      expected_dates.push_back(advance_date(c));
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_date(logic [15:0] y, logic [3:0] m, logic [4:0] d, logic [1:0] st);
      date_result_t exp;
      if (expected_dates.size() == 0) begin
        report($sformatf("unexpected result %0d-%0d-%0d status %0d", y, m, d, st));
        return;
      end
      exp = expected_dates.pop_front();
      n_checked++;
      if (exp.status == ST_INVALID) n_refused++;
      if (exp.status == ST_SATURATED) n_saturated++;
      if (y !== exp.year) report($sformatf("year got %0d exp %0d", y, exp.year));
      if (m !== exp.month) report($sformatf("month got %0d exp %0d", m, exp.month));
      if (d !== exp.day) report($sformatf("day got %0d exp %0d", d, exp.day));
      if (st !== exp.status) report($sformatf("status got %0d exp %0d", st, exp.status));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [15:0] amount_i;
  logic [15:0] load_year_i;
  logic [3:0]  load_month_i;
  logic [4:0]  load_day_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] cur_year_o;
  logic [3:0]  cur_month_o;
  logic [4:0]  cur_day_o;
  logic [1:0]  status_o;

  date_scoreboard sb = new();
  int unsigned    words_sent = 0;
  int unsigned    idle_cycles = 0;
  bit             tx_burst = 0;
  bit             rx_burst = 0;
  bit             hold_req = 0;

  calendar_date_adder dut (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic cmd_t mk(opcode_e op, int unsigned amt, int unsigned y,
                              int unsigned m, int unsigned d);
    cmd_t c;
    c.op = op;
    c.amount = amt[15:0];
    c.load_year = y[15:0];
    c.load_month = m[3:0];
    c.load_day = d[4:0];
    return c;
  endfunction

  function automatic logic [15:0] pick_year();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 16'($urandom);
    if (r < 45) return 16'($urandom_range(65400, 65535));
    if (r < 65) return 16'(100 * $urandom_range(0, 655));
    if (r < 85) return 16'($urandom_range(1890, 2110));
    return 16'($urandom_range(0, 20));
  endfunction

  function automatic cmd_t valid_load();
    cmd_t        c;
    int unsigned len;
    c = mk(OP_LOAD, $urandom, pick_year(), 1, 1);
    if ($urandom_range(0, 99) < 15) begin
      c.load_year = c.load_year & 16'hFFFC;
      c.load_month = 4'd2;
      c.load_day = 5'd29;
    end else begin
      c.load_month = 4'($urandom_range(1, 12));
      len = sb.days_in_month(c.load_year, c.load_month);
      c.load_day = 5'(($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len));
    end
    return c;
  endfunction

  function automatic cmd_t invalid_load();
    cmd_t        c;
    int unsigned thirty[4];
    thirty = '{4, 6, 9, 11};
    c = valid_load();
    case ($urandom_range(0, 4))
      0: c.load_month = 4'd0;
      1: c.load_month = 4'($urandom_range(13, 15));
      2: c.load_day = 5'd0;
      3: begin
        c.load_month = 4'(thirty[$urandom_range(0, 3)]);
        c.load_day = 5'd31;
      end
      default: begin
        c.load_month = 4'd2;
        c.load_day = 5'($urandom_range(sb.days_in_month(c.load_year, 2) + 1, 31));
      end
    endcase
    return c;
  endfunction

  function automatic cmd_t add_cmd();
    cmd_t        c;
    int unsigned r;
    int unsigned amt;
    r = $urandom_range(0, 99);
    if (r < 8) amt = 0;
    else if (r < 60) amt = $urandom_range(1, 40);
    else if (r < 85) amt = $urandom_range(41, 1500);
    else if (r < 93) amt = $urandom_range(0, 65535);
    else amt = $urandom_range(65000, 65535);
    c = mk(opcode_e'($urandom_range(1, 3)), amt, $urandom, $urandom, $urandom);
    return c;
  endfunction

  function automatic cmd_t noise_cmd();
    return mk(opcode_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_word(cmd_t c);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= c.op;
    amount_i <= c.amount;
    load_year_i <= c.load_year;
    load_month_i <= c.load_month;
    load_day_i <= c.load_day;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_command(c);
    words_sent++;
  endtask

  task automatic pause(int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_spaced(cmd_t c);
    send_word(c);
    pause(tx_burst ? 0 : gap_len());
  endtask

  task automatic wait_drained();
    pause(1);
    while (sb.expected_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_sequence();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_spaced(valid_load());
      repeat ($urandom_range(1, 8)) send_spaced(add_cmd());
    end else if (r < 85) begin
      send_spaced(invalid_load());
      repeat ($urandom_range(1, 3)) send_spaced(add_cmd());
    end else begin
      repeat ($urandom_range(1, 3)) send_spaced(noise_cmd());
    end
  endtask

  task automatic run_until(int unsigned target);
    while (words_sent < target) send_sequence();
  endtask

  task automatic directed_words();
    cmd_t list[$];
    list.push_back(mk(OP_ADD_DAYS, 0, 16'hFFFF, 15, 31));
    list.push_back(mk(OP_ADD_MONTHS, 0, 0, 0, 0));
    list.push_back(mk(OP_ADD_YEARS, 0, 16'hFFFF, 0, 0));
    list.push_back(mk(OP_LOAD, 16'hFFFF, 2000, 2, 29));
    list.push_back(mk(OP_ADD_YEARS, 1, 0, 0, 0));
    list.push_back(mk(OP_LOAD, 0, 1900, 2, 29));
    list.push_back(mk(OP_LOAD, 0, 2024, 1, 31));
    list.push_back(mk(OP_ADD_MONTHS, 1, 0, 0, 0));
    list.push_back(mk(OP_ADD_MONTHS, 12, 0, 0, 0));
    list.push_back(mk(OP_LOAD, 0, 2020, 0, 10));
    list.push_back(mk(OP_LOAD, 0, 2020, 13, 1));
    list.push_back(mk(OP_LOAD, 0, 16'hFFFF, 15, 31));
    list.push_back(mk(OP_LOAD, 0, 2020, 5, 0));
    list.push_back(mk(OP_LOAD, 0, 2021, 4, 31));
    list.push_back(mk(OP_LOAD, 0, 0, 1, 1));
    list.push_back(mk(OP_ADD_DAYS, 16'hFFFF, 0, 0, 0));
    list.push_back(mk(OP_LOAD, 0, 65535, 12, 31));
    list.push_back(mk(OP_ADD_YEARS, 0, 0, 0, 0));
    list.push_back(mk(OP_ADD_DAYS, 1, 0, 0, 0));
    list.push_back(mk(OP_LOAD, 0, 65535, 1, 31));
    list.push_back(mk(OP_ADD_MONTHS, 11, 0, 0, 0));
    list.push_back(mk(OP_ADD_MONTHS, 1, 0, 0, 0));
    list.push_back(mk(OP_LOAD, 0, 64800, 2, 29));
    list.push_back(mk(OP_ADD_YEARS, 16'hFFFF, 0, 0, 0));
    list.push_back(mk(OP_LOAD, 0, 2099, 12, 31));
    list.push_back(mk(OP_ADD_DAYS, 60, 0, 0, 0));
    foreach (list[i]) send_spaced(list[i]);
  endtask

  // receiver: random stalls, burst stretches, and one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
        out_ready_i <= 1'b1;
      end else if (rx_burst) begin
        out_ready_i <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = gap_len();
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      sb.check_date(cur_year_o, cur_month_o, cur_day_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    amount_i = '0;
    load_year_i = '0;
    load_month_i = '0;
    load_day_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_words();
    wait_drained();

    run_until(words_sent + 600);
    wait_drained();

    tx_burst = 1;
    rx_burst = 1;
    run_until(words_sent + 300);
    rx_burst = 0;

    hold_req = 1;
    repeat (20) send_word(add_cmd());
    tx_burst = 0;
    wait_drained();

    run_until(words_sent + 700);
    wait_drained();
    repeat (40) @(posedge clk_i);

    if (sb.expected_dates.size() != 0) sb.report("results still outstanding at end");
    $display("Covered %0d command words: %0d results checked, %0d refused loads, %0d saturated",
             words_sent, sb.n_checked, sb.n_refused, sb.n_saturated);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/cda_pkg.sv
design/cda_ctrl.sv
design/cda_datapath.sv
design/calendar_date_adder.sv
design/calendar_date_adder_chk.sv
sim/calendar_date_adder_tb.sv
